@@ hdl/assert_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/ffa_pkg.sv @@
// ---------------------------------------------------------------------------
// ffa_pkg
// Request and result types, commands and status shared by the allocator.
// ---------------------------------------------------------------------------
package ffa_pkg;

    // arena size and unit size; the 12-bit links and 13-bit sizes follow them
    localparam int HEAP_UNITS = 4096;
    localparam int UNIT_BYTES = 16;

    localparam int FUNC_ALLOC = 0;
    localparam int FUNC_FREE  = 1;

    typedef struct packed {
        logic        func;
        logic [15:0] nbytes;
        logic [11:0] payload_addr;
    } ffa_req_t;

    typedef struct packed {
        logic [11:0] addr;
        logic        failed;
    } ffa_rsp_t;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,        // latch request, compute units
        OP_INIT,        // write sentinel if list not started
        OP_AS_RD_PREV,  // read hdr[prev]
        OP_AS_LD_P,     // p = next(prev); read hdr[p]
        OP_AS_LD_HP,    // latch hdr[p]
        OP_AS_EXACT,    // hdr[prev].next = hp.next
        OP_AS_SPLIT1,   // hdr[p].size -= n
        OP_AS_SPLIT2,   // hdr[p + size] = (size n, next 0)
        OP_AS_ADV,      // prev = p, read hdr[p.next]
        OP_GROW,        // set grow block header, bp = brk
        OP_FR_START,    // bp = paddr-1, p = rover
        OP_RL_RD_P,     // read hdr[p]
        OP_RL_LD_P,     // latch hp, check stop, read hdr[n]
        OP_RL_LD_N,     // latch hn, read hdr[bp]
        OP_RL_LD_B,     // latch hb
        OP_RL_WR_B,     // write hdr[bp]
        OP_RL_WR_P,     // write hdr[p], rover = p
        OP_DONE_OK,
        OP_DONE_FAIL,
        OP_DONE_ZERO
    } ffa_op_t;

    typedef struct packed {
        logic is_free;
        logic free_ok;     // free passes its guards
        logic fit;         // size(p) >= n
        logic exact;       // size(p) == n
        logic p_is_rover;
        logic grow_ok;
        logic rl_stop;     // insertion point found
        logic walk_over;   // step bound hit on the search
        logic rl_over;     // step bound hit on the insertion walk
        logic from_grow;   // release called by a grow
    } ffa_stat_t;

endpackage

@@ hdl/ffa_datapath.sv @@
// ---------------------------------------------------------------------------
// ffa_datapath
// Header memory, list pointers and arithmetic of the allocator.
// ---------------------------------------------------------------------------
module ffa_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  ffa_pkg::ffa_req_t req,
    input  logic              cfg_we,
    input  logic [12:0]       cfg_data,
    input  ffa_pkg::ffa_op_t  op,
    output ffa_pkg::ffa_stat_t stat,
    output ffa_pkg::ffa_rsp_t rsp
);
    import ffa_pkg::*;

    localparam int AW = $clog2(HEAP_UNITS);
    localparam int UB = $clog2(UNIT_BYTES);
    localparam int WALK = 4 * HEAP_UNITS + 8;
    localparam int SW = $clog2(WALK + 1);

    // entry: next in low 12 bits, size in 13 bits above
    logic [24:0] mem [HEAP_UNITS];
    logic [24:0] rd_q;
    logic          rd_en;
    logic [AW-1:0] rd_a;
    logic          wr_en;
    logic [AW-1:0] wr_a;
    logic [24:0]   wr_d;

    logic        is_free_reg;
    logic [11:0] paddr_reg;
    logic [12:0] n_reg;
    logic [11:0] rover_reg, prev_reg, p_reg, bp_reg;
    logic [24:0] hp_reg, hn_reg, hb_reg;
    logic        started_reg;
    logic [12:0] brk_reg, mgu_reg;
    logic [SW-1:0] steps_reg;
    logic [SW-1:0] rl_steps_reg;
    logic        from_grow_reg;
    logic [11:0] addr_reg;
    logic        failed_reg;

    logic [16:0] nu_sum;
    logic [12:0] grow_n;
    logic [13:0] grow_end;
    logic [11:0] qn, hpn;
    logic [12:0] qs, hps;
    logic [12:0] newsz;
    logic [11:0] split_p;
    logic        merge_b, merge_p;

    assign qn  = rd_q[11:0];
    assign qs  = rd_q[24:12];
    assign hpn = hp_reg[11:0];
    assign hps = hp_reg[24:12];
    assign nu_sum = ({1'b0, req.nbytes} + 17'(UNIT_BYTES - 1)) >> UB;
    assign grow_n = (n_reg < mgu_reg) ? mgu_reg : n_reg;
    assign grow_end = {1'b0, brk_reg} + {1'b0, grow_n};
    assign newsz = hps - n_reg;
    assign split_p = p_reg + newsz[11:0];
    // neighbor merges, compared without wrap
    assign merge_b = ({2'b0, bp_reg} + {1'b0, hb_reg[24:12]}) == {2'b0, hpn};
    assign merge_p = ({2'b0, p_reg} + {1'b0, hps}) == {2'b0, bp_reg};

    always_comb
    begin
        rd_en = 1'b0;
        rd_a  = '0;
        wr_en = 1'b0;
        wr_a  = '0;
        wr_d  = '0;
        unique case (op)
            OP_INIT:
            begin
                wr_en = !started_reg;
                wr_d  = '0;
            end
            OP_AS_RD_PREV:
            begin
                rd_en = 1'b1; rd_a = prev_reg[AW-1:0];
            end
            OP_AS_LD_P:
            begin
                rd_en = 1'b1; rd_a = qn[AW-1:0];
            end
            OP_AS_EXACT:
            begin
                wr_en = 1'b1; wr_a = prev_reg[AW-1:0];
                wr_d  = {hn_reg[24:12], hpn};
            end
            OP_AS_SPLIT1:
            begin
                wr_en = 1'b1; wr_a = p_reg[AW-1:0]; wr_d = {newsz, hpn};
            end
            OP_AS_SPLIT2:
            begin
                wr_en = 1'b1; wr_a = split_p[AW-1:0]; wr_d = {n_reg, 12'd0};
            end
            OP_AS_ADV:
            begin
                rd_en = 1'b1; rd_a = hpn[AW-1:0];
            end
            OP_GROW:
            begin
                wr_en = 1'b1; wr_a = brk_reg[AW-1:0]; wr_d = {grow_n, 12'd0};
            end
            OP_RL_RD_P:
            begin
                rd_en = 1'b1; rd_a = p_reg[AW-1:0];
            end
            OP_RL_LD_P:
            begin
                rd_en = 1'b1; rd_a = qn[AW-1:0];
            end
            OP_RL_LD_N:
            begin
                rd_en = 1'b1; rd_a = bp_reg[AW-1:0];
            end
            OP_RL_WR_B:
            begin
                wr_en = 1'b1; wr_a = bp_reg[AW-1:0];
                if (merge_b)
                    wr_d = {hb_reg[24:12] + hn_reg[24:12], hn_reg[11:0]};
                else
                    wr_d = {hb_reg[24:12], hpn};
            end
            OP_RL_WR_P:
            begin
                wr_en = 1'b1; wr_a = p_reg[AW-1:0];
                if (merge_p)
                    wr_d = {hps + hb_reg[24:12], hb_reg[11:0]};
                else
                    wr_d = {hps, bp_reg};
            end
            default: ;
        endcase
    end

    // read data holds between reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_a] <= wr_d;
        if (rd_en)
            rd_q <= mem[rd_a];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rover_reg     <= '0;
            started_reg   <= 1'b0;
            brk_reg       <= 13'd1;
            mgu_reg       <= 13'd1024;
            addr_reg      <= '0;
            failed_reg    <= 1'b0;
            steps_reg     <= '0;
            rl_steps_reg  <= '0;
            from_grow_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mgu_reg <= cfg_data;
            unique case (op)
                OP_LOAD:
                begin
                    is_free_reg <= req.func;
                    paddr_reg   <= req.payload_addr;
                    n_reg       <= nu_sum[12:0] + 13'd1;
                    steps_reg   <= '0;
                end
                OP_INIT:
                begin
                    if (!started_reg)
                        rover_reg <= '0;
                    started_reg <= 1'b1;
                    prev_reg <= started_reg ? rover_reg : 12'd0;
                end
                OP_AS_LD_P:
                begin
                    p_reg  <= qn;
                    hn_reg <= rd_q;   // header of prev
                end
                OP_AS_LD_HP: hp_reg <= rd_q;
                OP_AS_EXACT:
                begin
                    rover_reg <= prev_reg;
                    addr_reg <= p_reg + 12'd1;
                    failed_reg <= 1'b0;
                end
                OP_AS_SPLIT2:
                begin
                    rover_reg <= prev_reg;
                    addr_reg <= split_p + 12'd1;
                    failed_reg <= 1'b0;
                end
                OP_AS_ADV:
                begin
                    prev_reg <= p_reg;
                    hn_reg <= hp_reg;
                    p_reg <= hpn;
                    steps_reg <= steps_reg + SW'(1);
                end
                OP_GROW:
                begin
                    bp_reg <= brk_reg[11:0];
                    brk_reg <= grow_end[12:0];
                    p_reg <= rover_reg;
                    from_grow_reg <= 1'b1;
                    rl_steps_reg <= '0;
                end
                OP_FR_START:
                begin
                    bp_reg <= paddr_reg - 12'd1;
                    p_reg <= rover_reg;
                    from_grow_reg <= 1'b0;
                    rl_steps_reg <= '0;
                    addr_reg <= '0;
                    failed_reg <= 1'b0;
                end
                OP_RL_LD_P:
                begin
                    hp_reg <= rd_q;
                    rl_steps_reg <= rl_steps_reg + SW'(1);
                    if (!stat.rl_stop && !stat.rl_over)
                        p_reg <= qn;
                end
                OP_RL_LD_N: hn_reg <= rd_q;
                OP_RL_LD_B: hb_reg <= rd_q;
                OP_RL_WR_B:
                    if (merge_b)
                        hb_reg <= {hb_reg[24:12] + hn_reg[24:12], hn_reg[11:0]};
                    else
                        hb_reg <= {hb_reg[24:12], hpn};
                OP_RL_WR_P:
                begin
                    rover_reg <= p_reg;
                    if (from_grow_reg)
                    begin
                        // search resumes at p = rover: prev will be set by ADV
                        hp_reg <= merge_p ? {hps + hb_reg[24:12], hb_reg[11:0]}
                                          : {hps, bp_reg};
                        from_grow_reg <= 1'b0;
                    end
                end
                OP_DONE_FAIL:
                begin
                    addr_reg <= '0; failed_reg <= 1'b1;
                end
                OP_DONE_ZERO:
                begin
                    addr_reg <= '0; failed_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // the stop test at the insertion walk uses the freshly read entry
    logic [11:0] ln;
    assign ln = qn;

    always_comb
    begin
        stat.is_free    = is_free_reg;
        stat.free_ok    = started_reg && paddr_reg != 12'd0
                          && {1'b0, paddr_reg - 12'd1} < brk_reg;
        stat.fit        = hps >= n_reg;
        stat.exact      = hps == n_reg;
        stat.p_is_rover = p_reg == rover_reg;
        stat.grow_ok    = !grow_end[13] ? (grow_end <= 14'(HEAP_UNITS)) : 1'b0;
        stat.rl_stop    = (bp_reg > p_reg && bp_reg < ln)
                          || (p_reg >= ln && (bp_reg > p_reg || bp_reg < ln));
        stat.walk_over  = steps_reg >= SW'(WALK);
        stat.rl_over    = rl_steps_reg >= SW'(WALK);
        stat.from_grow  = from_grow_reg;
    end

    assign rsp.addr   = addr_reg;
    assign rsp.failed = failed_reg;

endmodule

@@ hdl/ffa_ctrl.sv @@
// ---------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for allocate search, grow and free insertion.
// ---------------------------------------------------------------------------
module ffa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  ffa_pkg::ffa_stat_t stat,
    output ffa_pkg::ffa_op_t   op
);
    import ffa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_INIT, S_RDPREV, S_LDP, S_LDHP, S_TEST,
        S_SPLIT2, S_ADV, S_GROW, S_RLRD, S_RLLDP, S_RLLDN, S_RLLDB,
        S_RLWRB, S_RLWRP, S_RESP, S_WAIT1, S_GADV
    } state_t;

    state_t state_reg;
    logic   rsp_valid_reg;

    assign req_ready = state_reg == S_IDLE && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        op = OP_NONE;
        unique case (state_reg)
            S_IDLE:   op = (req_valid && req_ready) ? OP_LOAD : OP_NONE;
            S_DECODE:
                op = stat.is_free ? (stat.free_ok ? OP_FR_START : OP_DONE_ZERO)
                                  : OP_INIT;
            S_INIT:   op = OP_AS_RD_PREV;
            S_RDPREV: op = OP_NONE;
            S_LDP:    op = OP_AS_LD_P;
            S_WAIT1:  op = OP_NONE;
            S_LDHP:   op = OP_AS_LD_HP;
            S_TEST:
                priority if (stat.walk_over) op = OP_DONE_FAIL;
                else if (stat.fit) op = stat.exact ? OP_AS_EXACT : OP_AS_SPLIT1;
                else if (stat.p_is_rover)
                    op = stat.grow_ok ? OP_GROW : OP_DONE_FAIL;
                else op = OP_AS_ADV;
            S_SPLIT2: op = OP_AS_SPLIT2;
            S_ADV:    op = OP_NONE;
            S_GADV:   op = OP_AS_ADV;
            S_GROW:   op = OP_RL_RD_P;
            S_RLRD:   op = OP_NONE;
            S_RLLDP:  op = OP_RL_LD_P;
            S_RLLDN:  op = OP_RL_LD_N;
            S_RLLDB:  op = OP_RL_LD_B;
            S_RLWRB:  op = OP_RL_WR_B;
            S_RLWRP:  op = OP_RL_WR_P;
            S_RESP:   op = OP_NONE;
            default:  op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:   if (req_valid && req_ready) state_reg <= S_DECODE;
                S_DECODE:
                    if (stat.is_free && !stat.free_ok) state_reg <= S_RESP;
                    else if (stat.is_free) state_reg <= S_GROW;
                    else state_reg <= S_INIT;
                S_INIT:   state_reg <= S_RDPREV;
                S_RDPREV: state_reg <= S_LDP;
                S_LDP:    state_reg <= S_WAIT1;
                S_WAIT1:  state_reg <= S_LDHP;
                S_LDHP:   state_reg <= S_TEST;
                S_TEST:
                    priority if (stat.walk_over) state_reg <= S_RESP;
                    else if (stat.fit)
                        state_reg <= stat.exact ? S_RESP : S_SPLIT2;
                    else if (stat.p_is_rover)
                        state_reg <= stat.grow_ok ? S_GROW : S_RESP;
                    else state_reg <= S_ADV;
                S_SPLIT2: state_reg <= S_RESP;
                S_ADV:    state_reg <= S_LDHP;
                S_GADV:   state_reg <= S_ADV;
                S_GROW:   state_reg <= S_RLRD;
                S_RLRD:   state_reg <= S_RLLDP;
                S_RLLDP:
                    if (stat.rl_stop || stat.rl_over) state_reg <= S_RLLDN;
                    else state_reg <= S_RLRD;
                S_RLLDN:  state_reg <= S_RLLDB;
                S_RLLDB:  state_reg <= S_RLWRB;
                S_RLWRB:  state_reg <= S_RLWRP;
                S_RLWRP:
                    // after a grow, rover = p; advance from it with hp fresh
                    state_reg <= stat.from_grow ? S_GADV : S_RESP;
                S_RESP:
                begin
                    rsp_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ hdl/first_fit_free_list_allocator.sv @@
// First-fit free-list allocator. One request at a time: an allocate walks
// the free list from the rover, splitting a larger block, or growing the
// arena when it comes back round to the rover; a free walks to its
// insertion point and merges, and a free that fails its guards is ignored.
// The next request is taken the cycle after the result is. The header
// memory takes one access a cycle.
module first_fit_free_list_allocator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ffa_pkg::ffa_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output ffa_pkg::ffa_rsp_t rsp,
    input  logic              cfg_we,
    input  logic [12:0]       cfg_data
);
    import ffa_pkg::*;

    ffa_op_t   op;
    ffa_stat_t stat;

    ffa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_ready(req_ready),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .stat(stat), .op(op)
    );

    ffa_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .req(req), .cfg_we(cfg_we),
        .cfg_data(cfg_data), .op(op), .stat(stat), .rsp(rsp)
    );

endmodule

@@ hdl/ffa_checker.sv @@
// ---------------------------------------------------------------------------
// ffa_checker
// Port-level checks on the allocator handshakes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ffa_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input ffa_pkg::ffa_rsp_t rsp
);
    `ASSERT_NEXT(a_one_rsp, clk, rst_n, req_valid && req_ready, !req_ready)
    `ASSERT_IMPL(a_fail_zero, clk, rst_n, rsp_valid && rsp.failed, rsp.addr == 12'd0)
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind first_fit_free_list_allocator ffa_checker u_chk (
    .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_ready(req_ready),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);

@@ tb/allocator_checker.sv @@
// ---------------------------------------------------------------------------
// allocator_checker
// Watches the request and result channels of the allocator and predicts
// every result from its own copy of the free list and break pointer. Each
// accepted result is checked against the oldest prediction.
// ---------------------------------------------------------------------------
module allocator_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  ffa_pkg::ffa_req_t req,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  ffa_pkg::ffa_rsp_t rsp,
    input  logic              cfg_we,
    input  logic [12:0]       cfg_data,
    output int                errors,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ffa_pkg::*;

    localparam int unsigned UNITS     = 4096;
    localparam int unsigned UNIT_SZ   = 16;
    localparam int unsigned WALK_STOP = 4 * UNITS + 8;

    logic [24:0]  hdr_mem [UNITS];
    logic [11:0]  roving;
    bit           started;
    int unsigned  brk;
    int unsigned  grow_min;
    ffa_rsp_t     expected_rsps[$];

    function automatic int unsigned link_of(int unsigned a);
        return hdr_mem[a % UNITS][11:0];
    endfunction

    function automatic int unsigned units_of(int unsigned a);
        return hdr_mem[a % UNITS][24:12];
    endfunction

    function automatic void put_link(int unsigned a, int unsigned v);
        hdr_mem[a % UNITS][11:0] = 12'(v % UNITS);
    endfunction

    function automatic void put_units(int unsigned a, int unsigned v);
        hdr_mem[a % UNITS][24:12] = 13'(v);
    endfunction

    // Address-ordered insert with merge on both sides.
    function automatic void insert_block(int unsigned bp);
        int unsigned p;
        int unsigned n;
        p = roving;
        for (int unsigned s = 0; s < WALK_STOP; s++)
        begin
            n = link_of(p);
            if (bp > p && bp < n)
                break;
            if (p >= n && (bp > p || bp < n))
                break;
            p = n;
        end
        n = link_of(p);
        if (bp + units_of(bp) == n)
        begin
            put_units(bp, units_of(bp) + units_of(n));
            put_link(bp, link_of(n));
        end
        else
            put_link(bp, n);
        if (p + units_of(p) == bp)
        begin
            put_units(p, units_of(p) + units_of(bp));
            put_link(p, link_of(bp));
        end
        else
            put_link(p, bp);
        roving = 12'(p % UNITS);
    endfunction

    function automatic bit extend_arena(int unsigned need);
        int unsigned nu;
        int unsigned h;
        nu = (need < grow_min) ? grow_min : need;
        h  = brk;
        if (h + nu > UNITS)
            return 0;
        put_units(h, nu);
        brk = (h + nu) & 13'h1fff;
        insert_block(h);
        return 1;
    endfunction

    function automatic ffa_rsp_t serve_request(ffa_req_t r);
        ffa_rsp_t    res;
        int unsigned need;
        int unsigned prev;
        int unsigned p;
        int unsigned sz;
        res = '0;
        if (r.func == 1'(FUNC_FREE))
        begin
            if (started && r.payload_addr != 0 && r.payload_addr - 1 < brk)
                insert_block(r.payload_addr - 1);
            return res;
        end
        need = (r.nbytes + UNIT_SZ - 1) / UNIT_SZ + 1;
        if (!started)
        begin
            put_link(0, 0);
            put_units(0, 0);
            roving  = '0;
            started = 1;
        end
        prev = roving;
        p    = link_of(prev);
        for (int unsigned s = 0; s < WALK_STOP; s++)
        begin
            sz = units_of(p);
            if (sz >= need)
            begin
                if (sz == need)
                    put_link(prev, link_of(p));
                else
                begin
                    sz = sz - need;
                    put_units(p, sz);
                    p = (p + sz) % UNITS;
                    put_units(p, need);
                end
                roving   = 12'(prev % UNITS);
                res.addr = 12'(p + 1);
                return res;
            end
            if (p == roving)
            begin
                if (!extend_arena(need))
                begin
                    res.failed = 1'b1;
                    return res;
                end
                p = roving;
            end
            prev = p;
            p    = link_of(p);
        end
        res.failed = 1'b1;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ffa_rsp_t want;
        if (!rst_n)
        begin
            foreach (hdr_mem[i])
                hdr_mem[i] = '0;
            roving   = '0;
            started  = 0;
            brk      = 1;
            grow_min = 1024;
            errors   = 0;
            expected_rsps.delete();
            pending  = 0;
        end
        else
        begin
            if (cfg_we)
                grow_min = cfg_data;
            if (req_valid && req_ready)
                expected_rsps.push_back(serve_request(req));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: unexpected result addr=%0d failed=%0b",
                             $time, rsp.addr, rsp.failed);
                    errors++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.addr !== want.addr)
                    begin
                        $display("%0t: addr expected %0d actual %0d",
                                 $time, want.addr, rsp.addr);
                        errors++;
                    end
                    if (rsp.failed !== want.failed)
                    begin
                        $display("%0t: failed expected %0b actual %0b",
                                 $time, want.failed, rsp.failed);
                        errors++;
                    end
                end
            end
            pending = expected_rsps.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Drives allocate and free requests into the first-fit allocator, frees
// handed blocks and invalid addresses, and varies the grow register and
// the idling on both channels; the checker beside the block compares.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ffa_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    ffa_req_t    req = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    ffa_rsp_t    rsp;
    logic        cfg_we = 1'b0;
    logic [12:0] cfg_data = '0;
    int          errors;
    int          pending;

    int          idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
    int          hold_cycles = 0;
    int          cycles = 0;
    logic        sent_funcs[$];
    logic [11:0] live_blocks[$];

    always #5 clk = ~clk;

    first_fit_free_list_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    allocator_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Track live blocks from the results so frees stay valid.
    always @(posedge clk)
    begin
        logic was_free;
        if (rst_n && rsp_valid && rsp_ready && sent_funcs.size() != 0)
        begin
            was_free = sent_funcs.pop_front();
            if (was_free == 1'(FUNC_ALLOC) && !rsp.failed && rsp.addr != 0)
                live_blocks.push_back(rsp.addr);
        end
        if (rst_n && req_valid && req_ready)
            sent_funcs.push_back(req.func);
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (idle_mode == 2)
            rsp_ready <= ($urandom_range(99) >= 66);
        else if (idle_mode == 3)
            rsp_ready <= ($urandom_range(99) >= 20);
        else
            rsp_ready <= 1'b1;
    end

    task automatic send_req(logic fn, logic [15:0] nb, logic [11:0] pa);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 66 : (idle_mode == 3) ? 20 : 0;
        while ($urandom_range(99) < gap_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid        = 1'b1;
        req.func         = fn;
        req.nbytes       = nb;
        req.payload_addr = pa;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
        req_valid = 1'b0;
    endtask

    task automatic drain();
        while (sent_funcs.size() != 0 || pending != 0)
            @(negedge clk);
    endtask

    task automatic set_grow(logic [12:0] v);
        drain();
        cfg_we   = 1'b1;
        cfg_data = v;
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    task automatic free_some_live();
        int k;
        k = $urandom_range(live_blocks.size() - 1);
        send_req(1'(FUNC_FREE), 16'($urandom), live_blocks[k]);
        live_blocks.delete(k);
    endtask

    task automatic random_requests(int count);
        logic [15:0] nb;
        int          pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (live_blocks.size() != 0 && (live_blocks.size() > 40 || pick < 45))
                free_some_live();
            else if (pick < 48)
                send_req(1'(FUNC_FREE), 16'($urandom), '0);   // ignored free
            else
            begin
                pick = $urandom_range(99);
                if (pick < 80)
                    nb = 16'($urandom_range(256));
                else if (pick < 92)
                    nb = 16'($urandom_range(4000, 257));
                else if (pick < 97)
                    nb = 16'($urandom_range(65535, 4001));
                else
                    nb = (pick[0]) ? 16'hffff : 16'h0;
                send_req(1'(FUNC_ALLOC), nb, 12'($urandom));
            end
        end
    endtask

    initial
    begin
        logic [11:0] a;
        logic [11:0] b;
        logic [11:0] c;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // free before the list exists
        send_req(1'(FUNC_FREE), 16'hffff, 12'd5);
        send_req(1'(FUNC_ALLOC), 16'd0, 12'hfff);
        send_req(1'(FUNC_ALLOC), 16'd1, '0);
        send_req(1'(FUNC_ALLOC), 16'd16, '0);
        send_req(1'(FUNC_ALLOC), 16'd17, '0);
        send_req(1'(FUNC_FREE), '0, '0);
        send_req(1'(FUNC_FREE), '0, 12'hfff);       // beyond the break
        send_req(1'(FUNC_ALLOC), 16'hffff, '0);     // cannot fit
        drain();
        // merge on both sides: free outer blocks first, then the middle
        c = live_blocks.pop_back();
        b = live_blocks.pop_back();
        a = live_blocks.pop_back();
        send_req(1'(FUNC_FREE), '0, a);
        send_req(1'(FUNC_FREE), '0, c);
        send_req(1'(FUNC_FREE), '0, b);
        // allocate twice, free the oldest live block, then allocate again
        send_req(1'(FUNC_ALLOC), 16'd100, '0);
        send_req(1'(FUNC_ALLOC), 16'd100, '0);
        drain();
        b = live_blocks.pop_front();
        send_req(1'(FUNC_FREE), '0, b);
        send_req(1'(FUNC_ALLOC), 16'd100, '0);
        send_req(1'(FUNC_ALLOC), 16'd40000, '0);   // grows the arena
        drain();

        set_grow(13'd1);
        random_requests(300);
        // long receiver hold-off while requests keep coming
        hold_cycles = 400;
        random_requests(20);
        drain();

        idle_mode = 1;
        set_grow(13'd4096);
        random_requests(300);

        idle_mode = 2;
        set_grow(13'd0);
        random_requests(300);

        idle_mode = 3;
        set_grow(13'd8191);
        random_requests(200);

        idle_mode = 0;
        set_grow(13'd1024);
        random_requests(200);
        while (live_blocks.size() != 0)
            free_some_live();

        drain();
        repeat (50) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ffa_pkg.sv
hdl/ffa_datapath.sv
hdl/ffa_ctrl.sv
hdl/first_fit_free_list_allocator.sv
hdl/ffa_checker.sv
tb/allocator_checker.sv
tb/testbench.sv
